### rtl/core/rtcode_pkg.sv
`timescale 1ns / 1ps

package rtcode_pkg;

  localparam int unsigned CodeBits   = 16;
  localparam int unsigned RateWidth  = 32;
  localparam int unsigned ByteShift  = 3;
  localparam int unsigned TgtWidth   = RateWidth + ByteShift;
  // all sixteen weights add up to 99998471, below 2**27
  localparam int unsigned SumWidth   = 27;
  localparam int unsigned IdxWidth   = $clog2(CodeBits);

  typedef logic [TgtWidth-1:0] target_t;
  typedef logic [SumWidth-1:0] sum_t;
  typedef logic [CodeBits-1:0] code_t;
  typedef logic [IdxWidth-1:0] idx_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic    valid;
    target_t target;
    sum_t    sum;
    code_t   code;
  } stage_t;

  // bps weight of one code bit
  function automatic sum_t bit_weight(idx_t idx);
    sum_t w;
    case (idx)
      4'd0:    w = 27'd1525;
      4'd1:    w = 27'd3051;
      4'd2:    w = 27'd6103;
      4'd3:    w = 27'd12207;
      4'd4:    w = 27'd24414;
      4'd5:    w = 27'd48828;
      4'd6:    w = 27'd97656;
      4'd7:    w = 27'd195312;
      4'd8:    w = 27'd390625;
      4'd9:    w = 27'd781250;
      4'd10:   w = 27'd1562500;
      4'd11:   w = 27'd3125000;
      4'd12:   w = 27'd6250000;
      4'd13:   w = 27'd12500000;
      4'd14:   w = 27'd25000000;
      4'd15:   w = 27'd50000000;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/meter_rate_to_bit_weight_code_top.sv
`timescale 1ns / 1ps

// meter rate to bit-weight code
//
// input stream: one item per requested rate in bytes per second (s_axis).
// output stream: one item per input item, a 16-bit code whose weighted
// sum of fixed bps weights (1525 up to 50000000) is at least eight times
// the rate; rates above an eighth of the weight sum give all ones (m_axis).
//
// the datapath is a chain of 32 cells: sixteen upward cells, one per code
// bit from bit 0, then sixteen downward cells from bit 15 to bit 0. each
// cell holds one item in its own register and hands it to its neighbor
// every cycle that the chain advances.
// throughput: one item per cycle while the receiver does not stall, set by
// the one-stage-per-cell chain.
//
// the chain advances as a whole whenever the last cell is empty or its
// item is taken; while the receiver stalls with a result pending, the
// chain holds and s_axis_tready_o is low, otherwise an item is taken
// each cycle. reset clears all cell valid bits, so no output is shown.
module meter_rate_to_bit_weight_code_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] rate_bytes
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [15:0] rate_code
);

  localparam int unsigned NumBits = rtcode_pkg::CodeBits;

  rtcode_pkg::stage_t up_chain [NumBits+1];
  rtcode_pkg::stage_t dn_chain [NumBits+1];
  logic               advance;

  // whole chain moves when the output stage is free or drained
  assign advance = !dn_chain[NumBits].valid || m_axis_tready_i;

  // the target in bps is the rate shifted by three
  always_comb begin
    up_chain[0].valid  = s_axis_tvalid_i;
    up_chain[0].target = {s_axis_tdata_i, {rtcode_pkg::ByteShift{1'b0}}};
    up_chain[0].sum    = '0;
    up_chain[0].code   = '0;
  end

  for (genvar g = 0; g < NumBits; g++) begin : g_up
    rtcode_up_cell #(
      .BitIdx(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .stage_i (up_chain[g]),
      .stage_o (up_chain[g+1])
    );
  end

  assign dn_chain[0] = up_chain[NumBits];

  // downward cells visit the highest bit first
  for (genvar g = 0; g < NumBits; g++) begin : g_dn
    rtcode_dn_cell #(
      .BitIdx(NumBits - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .stage_i (dn_chain[g]),
      .stage_o (dn_chain[g+1])
    );
  end

  assign s_axis_tready_o = advance;
  assign m_axis_tvalid_o = dn_chain[NumBits].valid;
  assign m_axis_tdata_o  = dn_chain[NumBits].code;

endmodule

### rtl/core/rtcode_up_cell.sv
`timescale 1ns / 1ps

// upward pass: add this bit's weight while the sum is below the target
module rtcode_up_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  rtcode_pkg::stage_t  stage_i,
  output rtcode_pkg::stage_t  stage_o
);

  localparam rtcode_pkg::idx_t Idx = rtcode_pkg::idx_t'(BitIdx);

  logic               valid_q;
  rtcode_pkg::stage_t data_d, data_q;
  logic               below;

  always_comb begin
    data_d = stage_i;
    below  = {{(rtcode_pkg::TgtWidth - rtcode_pkg::SumWidth){1'b0}}, stage_i.sum}
             < stage_i.target;
    if (below) begin
      data_d.sum          = stage_i.sum + rtcode_pkg::bit_weight(Idx);
      data_d.code[BitIdx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

### rtl/core/rtcode_dn_cell.sv
`timescale 1ns / 1ps

// downward pass: drop this bit when the sum stays at or above the target
module rtcode_dn_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  rtcode_pkg::stage_t  stage_i,
  output rtcode_pkg::stage_t  stage_o
);

  localparam rtcode_pkg::idx_t Idx = rtcode_pkg::idx_t'(BitIdx);

  logic               valid_q;
  rtcode_pkg::stage_t data_d, data_q;
  rtcode_pkg::sum_t   reduced;

  always_comb begin
    data_d  = stage_i;
    // a set bit's weight is always still contained in the sum
    reduced = stage_i.sum - rtcode_pkg::bit_weight(Idx);
    if (stage_i.code[BitIdx] &&
        ({{(rtcode_pkg::TgtWidth - rtcode_pkg::SumWidth){1'b0}}, reduced}
         >= stage_i.target)) begin
      data_d.sum          = reduced;
      data_d.code[BitIdx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule

### rtl/core/rtcode_checker.sv
`timescale 1ns / 1ps

module rtcode_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // input side is open exactly when the output stage can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output stall");

  // nothing is shown while or right after reset is held
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // after a stall the result is still pending, so input ready follows output ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> s_axis_tready_o == m_axis_tready_i)
    else $error("ready while stalled");

  // an offered rate waits unchanged until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=> s_axis_tvalid_i && $stable(s_axis_tdata_i))
    else $error("offered rate withdrawn or changed");

endmodule

bind meter_rate_to_bit_weight_code_top rtcode_checker u_rtcode_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
